### sv/rhb_pkg.sv
// ----------------------------------------------------------------------------
// rhb_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package rhb_pkg;

    localparam int KIND_W     = 2;
    localparam int SAMPLE_W   = 32;
    localparam int ROW_W      = 32;
    localparam int COL_W      = 7;
    localparam int CNT_W      = 32;
    localparam int STAT_W     = 2;
    localparam int SHIFT_W    = 64;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int OUT_DATA_W = 72;
    localparam int OUT_PAD_W  = OUT_DATA_W - ROW_W - COL_W - CNT_W;

    // remainder bits resolved per cycle in the modulo unit
    localparam int MOD_RADIX_BITS = 4;

    localparam logic [KIND_W-1:0] KIND_VALUE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ROW_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FILE_END = 2'd2;

    localparam logic [MODE_W-1:0] MODE_REJECT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MODULO = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLAMP  = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_LOW  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_HIGH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_BINS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_OFFSET  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INCREMENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EMIT_DIM    = 3'd4;

    localparam logic [COL_W-1:0]      NUM_BINS_RESET = 7'd64;
    localparam logic [SAMPLE_W-1:0]   OFFSET_RESET   = 32'd1;

    localparam logic [2:0] ADDR_K    = 3'd0;
    localparam logic [2:0] ADDR_LOW  = 3'd1;
    localparam logic [2:0] ADDR_HIGH = 3'd2;
    localparam logic [2:0] ADDR_MOD  = 3'd3;
    localparam logic [2:0] ADDR_WALK = 3'd4;

    localparam logic [1:0] OUT_BIN    = 2'd0;
    localparam logic [1:0] OUT_REJECT = 2'd1;
    localparam logic [1:0] OUT_DIM    = 2'd2;

    typedef struct packed {
        logic       load_k;
        logic       addr_load;
        logic [2:0] addr_sel;
        logic       ram_rd;
        logic       ram_wr;
        logic       shift_step;
        logic       mod_start;
        logic       walk_clear;
        logic       walk_step;
        logic       row_end;
        logic       out_load;
        logic [1:0] out_sel;
    } rhb_cmd_t;

    typedef struct packed {
        logic              k_in_range;
        logic              k_neg;
        logic [MODE_W-1:0] mode;
        logic              emit_dim;
        logic              mod_done;
        logic              walk_done;
        logic              walk_hit;
        logic              out_free;
    } rhb_status_t;

endpackage

### sv/rhb_ram.sv
// ----------------------------------------------------------------------------
// rhb_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module rhb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/rhb_mod.sv
// ----------------------------------------------------------------------------
// rhb_mod
// iterative remainder of a 64-bit magnitude by the bin count
// ----------------------------------------------------------------------------
module rhb_mod import rhb_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [SHIFT_W-1:0] dividend,
    input  logic [COL_W-1:0]   divisor,
    output logic               done,
    output logic [COL_W-1:0]   remainder
);

    localparam int STEPS   = SHIFT_W / MOD_RADIX_BITS;
    localparam int STEP_CW = $clog2(STEPS);

    logic [SHIFT_W-1:0] dvd_reg, dvd_next;
    logic [COL_W-1:0]   rem_reg, rem_next;
    logic [STEP_CW-1:0] cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    always_comb begin
        logic [COL_W:0] trial;
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        trial    = '0;
        for (int i = 0; i < MOD_RADIX_BITS; i++) begin
            trial = {rem_next, dvd_next[SHIFT_W-1]};
            if (trial >= {1'b0, divisor}) begin
                trial = trial - {1'b0, divisor};
            end
            rem_next = trial[COL_W-1:0];
            dvd_next = {dvd_next[SHIFT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + STEP_CW'(1);
                if (cnt_reg == STEP_CW'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### sv/rhb_ctrl.sv
// ----------------------------------------------------------------------------
// rhb_ctrl
// sequencer for sample binning, row walk and end of file
// ----------------------------------------------------------------------------
module rhb_ctrl import rhb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic [KIND_W-1:0] s_kind,
    output logic              s_tready,
    input  rhb_status_t       status,
    output rhb_cmd_t          cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CHECK  = 3'd1;
    localparam logic [2:0] S_MOD    = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_REJECT = 3'd4;
    localparam logic [2:0] S_DIM    = 3'd5;
    localparam logic [2:0] S_WALK   = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb begin
        cmd        = '0;
        s_tready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (s_kind)
                        KIND_VALUE: begin
                            cmd.load_k = 1'b1;
                            state_next = S_CHECK;
                        end
                        KIND_ROW_END: begin
                            cmd.walk_clear = 1'b1;
                            state_next     = S_WALK;
                        end
                        KIND_FILE_END: begin
                            state_next = status.emit_dim ? S_DIM : S_IDLE;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHECK: begin
                if (status.k_in_range) begin
                    cmd.addr_sel  = ADDR_K;
                    cmd.ram_rd    = 1'b1;
                    cmd.addr_load = 1'b1;
                    state_next    = S_WRITE;
                end else begin
                    unique case (status.mode)
                        MODE_MODULO: begin
                            cmd.mod_start = 1'b1;
                            state_next    = S_MOD;
                        end
                        MODE_CLAMP: begin
                            cmd.addr_sel  = status.k_neg ? ADDR_LOW : ADDR_HIGH;
                            cmd.ram_rd    = 1'b1;
                            cmd.addr_load = 1'b1;
                            state_next    = S_WRITE;
                        end
                        default: begin
                            state_next = S_REJECT;
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (status.mod_done) begin
                    cmd.addr_sel  = ADDR_MOD;
                    cmd.ram_rd    = 1'b1;
                    cmd.addr_load = 1'b1;
                    state_next    = S_WRITE;
                end
            end
            S_WRITE: begin
                cmd.ram_wr     = 1'b1;
                cmd.shift_step = 1'b1;
                state_next     = S_IDLE;
            end
            S_REJECT: begin
                if (status.out_free) begin
                    cmd.out_sel  = OUT_REJECT;
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DIM: begin
                if (status.out_free) begin
                    cmd.out_sel  = OUT_DIM;
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_WALK: begin
                if (status.walk_done) begin
                    cmd.row_end = 1'b1;
                    state_next  = S_IDLE;
                end else if (status.walk_hit) begin
                    cmd.addr_sel = ADDR_WALK;
                    cmd.ram_rd   = 1'b1;
                    state_next   = S_EMIT;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.out_sel   = OUT_BIN;
                    cmd.out_load  = 1'b1;
                    cmd.walk_step = 1'b1;
                    state_next    = S_WALK;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/rhb_dp.sv
// ----------------------------------------------------------------------------
// rhb_dp
// settings, running shift, bin store with valid flags and result register
// ----------------------------------------------------------------------------
module rhb_dp import rhb_pkg::*; #(
    parameter int MAX_BINS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [SAMPLE_W-1:0]   s_sample,
    input  rhb_cmd_t              cmd,
    output rhb_status_t           status,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [ROW_W-1:0]      m_row_number,
    output logic [COL_W-1:0]      m_column,
    output logic [CNT_W-1:0]      m_count,
    output logic [STAT_W-1:0]     m_status,
    output logic                  m_last
);

    localparam int AW = $clog2(MAX_BINS);
    localparam logic [COL_W-1:0] MAX_N = COL_W'(MAX_BINS);

    // settings
    logic [COL_W-1:0]    num_bins_reg;
    logic [SAMPLE_W-1:0] offset_reg;
    logic [SAMPLE_W-1:0] incr_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic                emit_dim_reg;

    // running state
    logic [SHIFT_W-1:0]  shift_reg;
    logic [ROW_W-1:0]    rows_seen_reg;
    logic [SHIFT_W-1:0]  k_reg;
    logic [AW-1:0]       addr_reg;
    logic [MAX_BINS-1:0] valid_reg;
    logic [COL_W-1:0]    walk_reg;

    // result register
    logic                out_valid_reg;
    logic [ROW_W-1:0]    out_row_reg;
    logic [COL_W-1:0]    out_col_reg;
    logic [CNT_W-1:0]    out_cnt_reg;
    logic [STAT_W-1:0]   out_stat_reg;
    logic                out_last_reg;

    logic [COL_W-1:0]    n_eff;
    logic                k_neg;
    logic                k_in_range;
    logic [SHIFT_W-1:0]  k_mag;
    logic                mod_done;
    logic [COL_W-1:0]    mod_rem;
    logic [COL_W-1:0]    hi_idx;
    logic [COL_W-1:0]    mod_idx;
    logic [AW-1:0]       addr_mux;
    logic [CNT_W-1:0]    ram_rdata;
    logic [CNT_W-1:0]    old_cnt;
    logic [CNT_W-1:0]    new_cnt;
    logic [ROW_W-1:0]    row1;
    logic [MAX_BINS-1:0] later_mask;
    logic                walk_last;
    logic                out_free;
    logic [SHIFT_W-1:0]  offset_shift;
    logic [SHIFT_W-1:0]  cfg_shift;
    logic [SHIFT_W-1:0]  incr_ext;
    logic [SHIFT_W-1:0]  sample_ext;

    assign n_eff = (num_bins_reg == '0) ? COL_W'(1) :
                   (num_bins_reg > MAX_N) ? MAX_N : num_bins_reg;

    assign sample_ext   = {{(SHIFT_W-SAMPLE_W){s_sample[SAMPLE_W-1]}}, s_sample};
    assign incr_ext     = {{(SHIFT_W-SAMPLE_W){incr_reg[SAMPLE_W-1]}}, incr_reg};
    assign offset_shift = '0 - {{(SHIFT_W-SAMPLE_W){offset_reg[SAMPLE_W-1]}}, offset_reg};
    assign cfg_shift    = '0 - {{(SHIFT_W-SAMPLE_W){cfg_wr_data[SAMPLE_W-1]}},
                                cfg_wr_data[SAMPLE_W-1:0]};

    assign k_neg      = k_reg[SHIFT_W-1];
    assign k_in_range = ~|k_reg[SHIFT_W-1:COL_W] && (k_reg[COL_W-1:0] < n_eff);
    assign k_mag      = k_neg ? ('0 - k_reg) : k_reg;

    rhb_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.mod_start),
        .dividend  (k_mag),
        .divisor   (n_eff),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // true modulo of a negative index folds back from the top
    assign hi_idx  = n_eff - COL_W'(1);
    assign mod_idx = !k_neg ? mod_rem :
                     (mod_rem == '0) ? '0 : n_eff - mod_rem;

    always_comb begin
        unique case (cmd.addr_sel)
            ADDR_K:    addr_mux = k_reg[AW-1:0];
            ADDR_LOW:  addr_mux = '0;
            ADDR_HIGH: addr_mux = hi_idx[AW-1:0];
            ADDR_MOD:  addr_mux = mod_idx[AW-1:0];
            ADDR_WALK: addr_mux = walk_reg[AW-1:0];
            default:   addr_mux = '0;
        endcase
    end

    assign old_cnt = valid_reg[addr_reg] ? ram_rdata : '0;
    assign new_cnt = (&old_cnt) ? old_cnt : old_cnt + CNT_W'(1);

    rhb_ram #(
        .WIDTH (CNT_W),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .aclk    (aclk),
        .wr_en   (cmd.ram_wr),
        .wr_addr (addr_reg),
        .wr_data (new_cnt),
        .rd_en   (cmd.ram_rd),
        .rd_addr (addr_mux),
        .rd_data (ram_rdata)
    );

    always_comb begin
        for (int i = 0; i < MAX_BINS; i++) begin
            later_mask[i] = (COL_W'(i) > walk_reg) && (COL_W'(i) < n_eff);
        end
    end

    assign walk_last = ~|(valid_reg & later_mask);
    assign row1      = rows_seen_reg + ROW_W'(1);
    assign out_free  = !out_valid_reg || m_tready;

    always_comb begin
        status            = '0;
        status.k_in_range = k_in_range;
        status.k_neg      = k_neg;
        status.mode       = mode_reg;
        status.emit_dim   = emit_dim_reg;
        status.mod_done   = mod_done;
        status.walk_done  = walk_reg >= n_eff;
        status.walk_hit   = valid_reg[walk_reg[AW-1:0]];
        status.out_free   = out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_bins_reg <= NUM_BINS_RESET;
            offset_reg   <= OFFSET_RESET;
            incr_reg     <= '0;
            mode_reg     <= MODE_REJECT;
            emit_dim_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_NUM_BINS:    num_bins_reg <= cfg_wr_data[COL_W-1:0];
                REG_BIN_OFFSET:  offset_reg   <= cfg_wr_data[SAMPLE_W-1:0];
                REG_INCREMENT:   incr_reg     <= cfg_wr_data[SAMPLE_W-1:0];
                REG_REDUCE_MODE: mode_reg     <= cfg_wr_data[MODE_W-1:0];
                REG_EMIT_DIM:    emit_dim_reg <= cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '0 - {{(SHIFT_W-SAMPLE_W){OFFSET_RESET[SAMPLE_W-1]}},
                                   OFFSET_RESET};
            rows_seen_reg <= '0;
            valid_reg     <= '0;
            walk_reg      <= '0;
        end else begin
            if (cfg_wr_en && cfg_wr_index == REG_BIN_OFFSET) begin
                shift_reg <= cfg_shift;
            end else if (cmd.row_end) begin
                shift_reg <= offset_shift;
            end else if (cmd.shift_step) begin
                shift_reg <= shift_reg + incr_ext;
            end
            if (cmd.row_end) begin
                rows_seen_reg <= row1;
                valid_reg     <= '0;
            end else if (cmd.ram_wr) begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (cmd.walk_clear) begin
                walk_reg <= '0;
            end else if (cmd.walk_step) begin
                walk_reg <= walk_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_k) begin
            k_reg <= sample_ext + shift_reg;
        end
        if (cmd.addr_load) begin
            addr_reg <= addr_mux;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            unique case (cmd.out_sel)
                OUT_BIN: begin
                    out_row_reg  <= row1;
                    out_col_reg  <= walk_reg + COL_W'(1);
                    out_cnt_reg  <= ram_rdata;
                    out_stat_reg <= STATUS_OK;
                    out_last_reg <= walk_last;
                end
                OUT_REJECT: begin
                    out_row_reg  <= row1;
                    out_col_reg  <= '0;
                    out_cnt_reg  <= '0;
                    out_stat_reg <= k_neg ? STATUS_LOW : STATUS_HIGH;
                    out_last_reg <= 1'b1;
                end
                OUT_DIM: begin
                    out_row_reg  <= rows_seen_reg;
                    out_col_reg  <= n_eff;
                    out_cnt_reg  <= '0;
                    out_stat_reg <= STATUS_OK;
                    out_last_reg <= 1'b1;
                end
                default: begin
                    out_row_reg  <= '0;
                    out_col_reg  <= '0;
                    out_cnt_reg  <= '0;
                    out_stat_reg <= STATUS_OK;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_row_number = out_row_reg;
    assign m_column     = out_col_reg;
    assign m_count      = out_cnt_reg;
    assign m_status     = out_stat_reg;
    assign m_last       = out_last_reg;

`ifndef ASSERT_OFF
    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ram_wr |-> (COL_W'(addr_reg) < n_eff))
        else $error("bin write beyond bins in use");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    a_row_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.row_end |=> (valid_reg == '0))
        else $error("bins not cleared at end of row");

    a_bin_from_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load && cmd.out_sel == OUT_BIN) |-> (valid_reg[walk_reg[AW-1:0]]
            && walk_reg < n_eff))
        else $error("bin result from an empty bin");
`endif

endmodule

### sv/row_histogram_binner.sv
// ----------------------------------------------------------------------------
// row_histogram_binner
// item: in-range or clamped is loaded, checked, written to its bin; rejected is
//   loaded, checked, reported; modulo adds 16 passes of 4 bits over 64 bits
// end of row: walks each bin in use, emitting a result for every nonzero bin
// one item in flight at a time; results wait in an output register
// reset: synchronous active low; bins start empty through per-bin valid flags,
//   so no clearing pass is needed after reset or at end of row
// ----------------------------------------------------------------------------
module row_histogram_binner import rhb_pkg::*; #(
    parameter int MAX_BINS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,   // sample
    input  logic [KIND_W-1:0]     s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // row_number, column, count, zero pad
    output logic [STAT_W-1:0]     m_tuser,   // status
    output logic                  m_tlast
);

    rhb_cmd_t         cmd;
    rhb_status_t      status;
    logic [ROW_W-1:0] row_number;
    logic [COL_W-1:0] column;
    logic [CNT_W-1:0] count;

    rhb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_kind   (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rhb_dp #(
        .MAX_BINS (MAX_BINS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_sample     (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_row_number (row_number),
        .m_column     (column),
        .m_count      (count),
        .m_status     (m_tuser),
        .m_last       (m_tlast)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, count, column, row_number};

endmodule
